// File: rtl/core/fan_curve_interpolator_defines.svh
// ----------------------------------------------------------------------------
// Fan curve interpolator assertion macros
// Shorthand for the clocked checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef FAN_CURVE_INTERPOLATOR_DEFINES_SVH
`define FAN_CURVE_INTERPOLATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FCI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FCI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/fci_pkg.sv
// ----------------------------------------------------------------------------
// Fan curve interpolator package
// Field widths, operation and status codes, and the stored node layout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fci_pkg;

  // Field widths of the request and result.
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned TEMP_W  = 10;
  localparam int unsigned SPEED_W = 14;
  localparam int unsigned QUERY_W = 16;

  // The interpolation product and the divider that consumes it.
  localparam int unsigned PROD_W    = TEMP_W + SPEED_W;
  localparam int unsigned DIV_CNT_W = $clog2(PROD_W + 1);

  // Defaults of the top-level parameters.
  localparam int unsigned MAX_NODES_DEF   = 10;
  localparam int unsigned TEMP_LIMIT_DEF  = 999;
  localparam int unsigned SPEED_LIMIT_DEF = 9999;

  // Operation codes.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_NODE = 2'd1,
    STATUS_NO_CURVE = 2'd2
  } status_e;

  // One curve node as it sits in the node memory.
  typedef struct packed {
    logic [TEMP_W-1:0]  temp;
    logic [SPEED_W-1:0] speed;
  } node_t;

endpackage

`default_nettype wire

// File: rtl/core/fci_node_mem.sv
// ----------------------------------------------------------------------------
// Fan curve node memory
// Single-port-write, registered-read memory holding both curve banks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fci_node_mem
  import fci_pkg::*;
#(
  parameter  int unsigned DEPTH  = 2 * MAX_NODES_DEF,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire node_t             wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output node_t                  rdata_o
);

  node_t mem_q [DEPTH];
  node_t rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/core/fci_div.sv
// ----------------------------------------------------------------------------
// Fan curve divider
// Restoring divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fci_div
  import fci_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [PROD_W-1:0] dividend_i,
  input  wire logic [TEMP_W-1:0] divisor_i,
  output logic                   done_o,
  output logic [PROD_W-1:0]      quotient_o
);

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [TEMP_W-1:0]    rem_q;
  logic [PROD_W-1:0]    quo_q;
  logic [TEMP_W-1:0]    dvs_q;

  logic [TEMP_W:0]      rem_sh;
  logic [TEMP_W:0]      rem_sub;
  logic                 fits;

  // One restoring step: shift in the next dividend bit and try to subtract.
  always_comb begin
    rem_sh  = {rem_q, quo_q[PROD_W-1]};
    fits    = (rem_sh >= {1'b0, dvs_q});
    rem_sub = rem_sh - {1'b0, dvs_q};
  end

  // Control: bit counter and completion pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(PROD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: the quotient shifts in where the dividend shifts out.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? rem_sub[TEMP_W-1:0] : rem_sh[TEMP_W-1:0];
      quo_q <= {quo_q[PROD_W-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// File: rtl/core/fan_curve_interpolator.sv
// ----------------------------------------------------------------------------
// Fan curve interpolator
// A node write goes from the idle state through S_OUT to the output register.
// A query without a curve does the same. A query with a curve reads the active
// bank from the node memory one node per cycle until it finds its segment. A
// clamp or an exact node hit then goes through S_OUT. A point between two nodes
// adds a multiply step and a restoring divide of 24 quotient bits. One request
// is in work at a time. A finished result waits in the output register while
// the next request is taken, in the same cycle that the result shows. The node
// memory needs no clearing after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "fan_curve_interpolator_defines.svh"

module fan_curve_interpolator
  import fci_pkg::*;
#(
  parameter int unsigned MAX_NODES   = MAX_NODES_DEF,
  parameter int unsigned TEMP_LIMIT  = TEMP_LIMIT_DEF,
  parameter int unsigned SPEED_LIMIT = SPEED_LIMIT_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               operation_i,
  input  wire logic [IDX_W-1:0]   node_index_i,
  input  wire logic [TEMP_W-1:0]  bp_temp_i,
  input  wire logic [SPEED_W-1:0] bp_speed_i,
  input  wire logic               last_node_i,
  input  wire logic [QUERY_W-1:0] query_temp_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [SPEED_W-1:0]      target_speed_o,
  output logic [1:0]              status_o
);

  localparam int unsigned DEPTH  = 2 * MAX_NODES;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(MAX_NODES + 1);
  localparam int unsigned CMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  // Control state.
  logic [2:0]         state_q, state_d;
  logic [CNT_W-1:0]   idx_q, idx_d;
  logic               active_bank_q, active_bank_d;
  logic [CNT_W-1:0]   active_size_q, active_size_d;
  logic [CNT_W-1:0]   load_count_q, load_count_d;
  logic [TEMP_W-1:0]  prev_temp_q, prev_temp_d;
  logic [SPEED_W-1:0] prev_speed_q, prev_speed_d;
  logic               out_valid_q, out_valid_d;

  // Payload registers.
  logic [QUERY_W-1:0] qry_q, qry_d;
  logic [TEMP_W-1:0]  seg_t_q, seg_t_d;
  logic [SPEED_W-1:0] seg_s_q, seg_s_d;
  logic [TEMP_W-1:0]  diff_q, diff_d;
  logic [TEMP_W-1:0]  dx_q, dx_d;
  logic [SPEED_W-1:0] dy_q, dy_d;
  logic [SPEED_W-1:0] res_speed_q, res_speed_d;
  status_e            res_status_q, res_status_d;
  logic [SPEED_W-1:0] out_speed_q, out_speed_d;
  status_e            out_status_q, out_status_d;

  // Memory and divider connections.
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  node_t              mem_wdata;
  logic [ADDR_W-1:0]  mem_raddr;
  node_t              mem_rdata;
  logic [CNT_W-1:0]   rd_idx;
  logic               div_start;
  logic [PROD_W-1:0]  div_dividend;
  logic               div_done;
  logic [PROD_W-1:0]  div_quotient;

  // Write checks.
  logic               in_accept;
  logic               idx_zero;
  logic [CNT_W-1:0]   expect_idx;
  logic               node_bad;
  logic               out_free;

  fci_node_mem #(
    .DEPTH (DEPTH)
  ) u_node_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  fci_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (dx_q),
    .done_o     (div_done),
    .quotient_o (div_quotient)
  );

  assign in_accept = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  // Node checks for a write request.
  always_comb begin
    idx_zero   = (node_index_i == '0);
    expect_idx = idx_zero ? '0 : load_count_q;
    node_bad   = (CMP_W'(node_index_i) >= CMP_W'(MAX_NODES)) ||
                 (CMP_W'(node_index_i) != CMP_W'(expect_idx)) ||
                 (bp_temp_i > TEMP_W'(TEMP_LIMIT)) ||
                 (bp_speed_i > SPEED_W'(SPEED_LIMIT)) ||
                 (!idx_zero && ((bp_temp_i <= prev_temp_q) ||
                                (bp_speed_i < prev_speed_q)));
  end

  // Memory write goes to the inactive bank.
  always_comb begin
    mem_we          = in_accept && (operation_i == OP_WRITE) && !node_bad;
    mem_waddr       = active_bank_q ? ADDR_W'(node_index_i)
                                    : ADDR_W'(MAX_NODES) + ADDR_W'(node_index_i);
    mem_wdata.temp  = bp_temp_i;
    mem_wdata.speed = bp_speed_i;
  end

  // The read address runs one node ahead of the node being examined.
  always_comb begin
    if (state_q == S_IDLE) begin
      rd_idx = '0;
    end else if ((idx_q + CNT_W'(1)) < active_size_q) begin
      rd_idx = idx_q + CNT_W'(1);
    end else begin
      rd_idx = idx_q;
    end
    mem_raddr = active_bank_q ? ADDR_W'(MAX_NODES) + ADDR_W'(rd_idx) : ADDR_W'(rd_idx);
  end

  // Interpolation product feeds the divider straight from registers.
  assign div_start    = (state_q == S_MUL);
  assign div_dividend = PROD_W'(diff_q) * PROD_W'(dy_q);

  // Sequencer: write handling, segment scan, divide and result hand-off.
  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    active_bank_d = active_bank_q;
    active_size_d = active_size_q;
    load_count_d  = load_count_q;
    prev_temp_d   = prev_temp_q;
    prev_speed_d  = prev_speed_q;
    qry_d         = qry_q;
    seg_t_d       = seg_t_q;
    seg_s_d       = seg_s_q;
    diff_d        = diff_q;
    dx_d          = dx_q;
    dy_d          = dy_q;
    res_speed_d   = res_speed_q;
    res_status_d  = res_status_q;
    out_valid_d   = out_valid_q && out_stall_i;
    out_speed_d   = out_speed_q;
    out_status_d  = out_status_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          qry_d       = query_temp_i;
          idx_d       = '0;
          res_speed_d = '0;
          if (operation_i == OP_WRITE) begin
            state_d = S_OUT;
            if (node_bad) begin
              res_status_d = STATUS_BAD_NODE;
              load_count_d = '0;
            end else begin
              res_status_d = STATUS_OK;
              prev_temp_d  = bp_temp_i;
              prev_speed_d = bp_speed_i;
              load_count_d = CNT_W'(node_index_i) + CNT_W'(1);
              if (last_node_i) begin
                active_bank_d = !active_bank_q;
                active_size_d = CNT_W'(node_index_i) + CNT_W'(1);
                load_count_d  = '0;
              end
            end
          end else if (active_size_q == '0) begin
            res_status_d = STATUS_NO_CURVE;
            state_d      = S_OUT;
          end else begin
            res_status_d = STATUS_OK;
            state_d      = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        seg_t_d = mem_rdata.temp;
        seg_s_d = mem_rdata.speed;
        idx_d   = idx_q + CNT_W'(1);
        if (idx_q == '0) begin
          // Clamp at or below the first node, or a single-node curve.
          if ((qry_q <= QUERY_W'(mem_rdata.temp)) || (active_size_q == CNT_W'(1))) begin
            res_speed_d = mem_rdata.speed;
            state_d     = S_OUT;
          end
        end else if (qry_q < QUERY_W'(mem_rdata.temp)) begin
          if (qry_q == QUERY_W'(seg_t_q)) begin
            res_speed_d = seg_s_q;
            state_d     = S_OUT;
          end else begin
            diff_d      = qry_q[TEMP_W-1:0] - seg_t_q;
            dx_d        = mem_rdata.temp - seg_t_q;
            dy_d        = (mem_rdata.speed >= seg_s_q) ? mem_rdata.speed - seg_s_q : '0;
            res_speed_d = seg_s_q;
            state_d     = S_MUL;
          end
        end else if (idx_q == active_size_q - CNT_W'(1)) begin
          // Clamp at or above the last node.
          res_speed_d = mem_rdata.speed;
          state_d     = S_OUT;
        end
      end

      S_MUL: begin
        state_d = S_DIV;
      end

      S_DIV: begin
        if (div_done) begin
          res_speed_d = res_speed_q + div_quotient[SPEED_W-1:0];
          state_d     = S_OUT;
        end
      end

      S_OUT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_speed_d  = res_speed_q;
          out_status_d = res_status_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      idx_q         <= '0;
      active_bank_q <= 1'b0;
      active_size_q <= '0;
      load_count_q  <= '0;
      prev_temp_q   <= '0;
      prev_speed_q  <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      idx_q         <= idx_d;
      active_bank_q <= active_bank_d;
      active_size_q <= active_size_d;
      load_count_q  <= load_count_d;
      prev_temp_q   <= prev_temp_d;
      prev_speed_q  <= prev_speed_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    qry_q        <= qry_d;
    seg_t_q      <= seg_t_d;
    seg_s_q      <= seg_s_d;
    diff_q       <= diff_d;
    dx_q         <= dx_d;
    dy_q         <= dy_d;
    res_speed_q  <= res_speed_d;
    res_status_q <= res_status_d;
    out_speed_q  <= out_speed_d;
    out_status_q <= out_status_d;
  end

  assign out_valid_o    = out_valid_q;
  assign target_speed_o = out_speed_q;
  assign status_o       = out_status_q;

  // Checks on the sequencer and the result.
  `FCI_ASSERT_NEXT(a_one_in_work, in_valid_i && !in_stall_o, in_stall_o, "request taken while busy")
  `FCI_ASSERT_NOW(a_err_zero, out_valid_o && (status_o != STATUS_OK), target_speed_o == '0, "error result carries a speed")
  `FCI_ASSERT_NOW(a_size_bound, 1'b1, active_size_q <= CNT_W'(MAX_NODES), "curve size out of range")
  `FCI_ASSERT_NOW(a_div_owner, div_done, state_q == S_DIV, "divider finished outside the divide step")

endmodule

`default_nettype wire

// File: tb/fan_curve_interpolator_tb.sv
// ----------------------------------------------------------------------------
// Fan curve interpolator testbench
// Loads temperature-to-speed curves, broken and well formed, and queries them.
// A scoreboard class keeps its own copy of both node banks and the load state.
// It predicts each result and compares it with what the block returns. Both
// handshakes idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// One expected result: the speed and the status of a request.
typedef struct packed {
  logic [fci_pkg::SPEED_W-1:0] speed;
  fci_pkg::status_e            status;
} fan_result_t;

class fan_curve_scoreboard;
  // Shadow of the node memory, two banks of MAX_NODES entries each.
  fci_pkg::node_t              node_mem [2*fci_pkg::MAX_NODES_DEF];
  bit                          bank;
  int unsigned                 active_len;
  int unsigned                 load_count;
  logic [fci_pkg::TEMP_W-1:0]  prev_temp;
  logic [fci_pkg::SPEED_W-1:0] prev_speed;
  fan_result_t                 expected_results [$];

  int unsigned mismatches;
  int unsigned n_writes, n_rejected, n_queries, n_no_curve, n_interpolated, n_endpoint;

  function new();
    bank = 1'b0;
    active_len = 0;
    load_count = 0;
    prev_temp = '0;
    prev_speed = '0;
    mismatches = 0;
    n_writes = 0;
    n_rejected = 0;
    n_queries = 0;
    n_no_curve = 0;
    n_interpolated = 0;
    n_endpoint = 0;
  endfunction

  task report(string msg);
    if (mismatches < 50) $display("[%0t] ERROR: %s", $realtime, msg);
    mismatches++;
  endtask

  function int unsigned pending();
    return expected_results.size();
  endfunction

  // A node write: checks the node against the load in progress and, on the
  // last node, makes the freshly loaded bank the active curve.
  function fci_pkg::status_e predict_node_write(logic [fci_pkg::IDX_W-1:0] idx,
                                                logic [fci_pkg::TEMP_W-1:0] t,
                                                logic [fci_pkg::SPEED_W-1:0] s,
                                                logic last);
    int unsigned slot;
    slot = (bank ? 0 : fci_pkg::MAX_NODES_DEF) + idx;
    if (idx == 0) load_count = 0;
    if (idx >= fci_pkg::MAX_NODES_DEF || idx != load_count ||
        t > fci_pkg::TEMP_LIMIT_DEF || s > fci_pkg::SPEED_LIMIT_DEF ||
        (idx > 0 && (t <= prev_temp || s < prev_speed))) begin
      load_count = 0;
      return fci_pkg::STATUS_BAD_NODE;
    end
    node_mem[slot].temp = t;
    node_mem[slot].speed = s;
    prev_temp = t;
    prev_speed = s;
    load_count = idx + 1;
    if (last) begin
      bank = ~bank;
      active_len = load_count;
      load_count = 0;
    end
    return fci_pkg::STATUS_OK;
  endfunction

  // A query against the active curve: clamp at both ends, otherwise a linear
  // step between the two nodes around the temperature, rounded down.
  function logic [fci_pkg::SPEED_W-1:0] predict_speed(logic [fci_pkg::QUERY_W-1:0] q);
    int unsigned base, top, i, t0, t1, s0, s1, dy;
    base = bank ? fci_pkg::MAX_NODES_DEF : 0;
    top = base + active_len - 1;
    if (active_len == 1 || q <= node_mem[base].temp) begin
      n_endpoint++;
      return node_mem[base].speed;
    end
    if (q >= node_mem[top].temp) begin
      n_endpoint++;
      return node_mem[top].speed;
    end
    for (i = base; i < top; i++) begin
      t0 = node_mem[i].temp;
      t1 = node_mem[i+1].temp;
      s0 = node_mem[i].speed;
      s1 = node_mem[i+1].speed;
      if (q == t0) begin
        n_endpoint++;
        return s0[fci_pkg::SPEED_W-1:0];
      end
      if (q > t0 && q < t1) begin
        n_interpolated++;
        dy = (s1 >= s0) ? s1 - s0 : 0;
        return fci_pkg::SPEED_W'(s0 + ((q - t0) * dy) / (t1 - t0));
      end
    end
    return node_mem[top].speed;
  endfunction

  // Called for every accepted request.
  task note_request(logic op, logic [fci_pkg::IDX_W-1:0] idx,
                    logic [fci_pkg::TEMP_W-1:0] t, logic [fci_pkg::SPEED_W-1:0] s,
                    logic last, logic [fci_pkg::QUERY_W-1:0] q);
    fan_result_t res;
    res.speed = '0;
    res.status = fci_pkg::STATUS_OK;
    if (op == fci_pkg::OP_WRITE) begin
      n_writes++;
      res.status = predict_node_write(idx, t, s, last);
      if (res.status != fci_pkg::STATUS_OK) n_rejected++;
    end else begin
      n_queries++;
      if (active_len == 0) begin
        n_no_curve++;
        res.status = fci_pkg::STATUS_NO_CURVE;
      end else begin
        res.speed = predict_speed(q);
      end
    end
    expected_results.push_back(res);
  endtask

  // Called for every accepted result.
  task check_result(logic [fci_pkg::SPEED_W-1:0] speed, logic [1:0] status);
    fan_result_t want;
    if (expected_results.size() == 0) begin
      report($sformatf("result speed %0d status %0d with no request pending",
                       speed, status));
      return;
    end
    want = expected_results.pop_front();
    if (speed !== want.speed)
      report($sformatf("target_speed %0d, expected %0d", speed, want.speed));
    if (status !== want.status)
      report($sformatf("status %0d, expected %0d", status, want.status));
  endtask
endclass

module fan_curve_interpolator_tb;
  import fci_pkg::*;

  localparam int unsigned NODES         = MAX_NODES_DEF;
  localparam int unsigned TEMP_MAX      = TEMP_LIMIT_DEF;
  localparam int unsigned SPEED_MAX     = SPEED_LIMIT_DEF;
  localparam int unsigned RANDOM_ITEMS  = 800;
  localparam int unsigned DRAIN_CYCLES  = 100;
  localparam int unsigned CYCLE_LIMIT   = 500000;

  // Ways a random load can go wrong.
  typedef enum int unsigned {
    FLAW_NONE,
    FLAW_TEMP_RANGE,
    FLAW_SPEED_RANGE,
    FLAW_SKIP_INDEX,
    FLAW_INDEX_RANGE,
    FLAW_TEMP_ORDER,
    FLAW_SPEED_ORDER,
    FLAW_ABANDON
  } flaw_e;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               operation = OP_WRITE;
  logic [IDX_W-1:0]   node_index = '0;
  logic [TEMP_W-1:0]  bp_temp = '0;
  logic [SPEED_W-1:0] bp_speed = '0;
  logic               last_node = 1'b0;
  logic [QUERY_W-1:0] query_temp = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [SPEED_W-1:0] target_speed;
  logic [1:0]         status;

  fan_curve_scoreboard sb = new();

  bit                 tx_idle = 1'b1;
  bit                 rx_idle = 1'b1;
  int unsigned        items_sent = 0;
  int unsigned        cycle_count = 0;
  // Temperatures of the last curve loaded without a flaw, to aim queries.
  logic [TEMP_W-1:0]  known_temp [NODES];
  int unsigned        known_size = 0;

  fan_curve_interpolator DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .operation_i    (operation),
    .node_index_i   (node_index),
    .bp_temp_i      (bp_temp),
    .bp_speed_i     (bp_speed),
    .last_node_i    (last_node),
    .query_temp_i   (query_temp),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .target_speed_o (target_speed),
    .status_o       (status)
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Every accepted request feeds the scoreboard.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      sb.note_request(operation, node_index, bp_temp, bp_speed, last_node, query_temp);
  end

  // Every accepted result is checked.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(target_speed, status);
  end

  // Result side: stall at random before each result.
  initial begin : result_sink
    int unsigned hold;
    wait (rst_n);
    forever begin
      hold = rx_idle ? $urandom_range(0, 5) : 0;
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Watchdog.
  initial begin : watchdog
    do begin
      @(posedge clk);
      cycle_count++;
    end while (cycle_count < CYCLE_LIMIT);
    $display("Timeout after %0d cycles with %0d results outstanding.",
             cycle_count, sb.pending());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Drives one request and returns at the edge where it is accepted.
  task automatic send_request(input logic op, input logic [IDX_W-1:0] idx,
                              input logic [TEMP_W-1:0] t, input logic [SPEED_W-1:0] s,
                              input logic last, input logic [QUERY_W-1:0] q);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 5) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    operation  <= op;
    node_index <= idx;
    bp_temp    <= t;
    bp_speed   <= s;
    last_node  <= last;
    query_temp <= q;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic write_node(input logic [IDX_W-1:0] idx, input logic [TEMP_W-1:0] t,
                            input logic [SPEED_W-1:0] s, input logic last);
    send_request(OP_WRITE, idx, t, s, last, 16'($urandom));
  endtask

  task automatic query_speed(input logic [QUERY_W-1:0] q);
    send_request(OP_QUERY, 4'($urandom), 10'($urandom), 14'($urandom), 1'($urandom), q);
  endtask

  // Holds off new requests until every outstanding result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // A random curve, sometimes with one flaw that must abort the load.
  task automatic load_random_curve();
    logic [TEMP_W-1:0]  t [NODES];
    logic [SPEED_W-1:0] s [NODES];
    int unsigned        n, k, at, room, idx;
    flaw_e              flaw;
    n = ($urandom_range(0, 3) == 0) ? NODES : $urandom_range(1, NODES);
    t[0] = 10'($urandom_range(0, 300));
    s[0] = 14'($urandom_range(0, 3000));
    for (k = 1; k < n; k++) begin
      room = (TEMP_MAX - t[k-1]) / (n - k);
      t[k] = t[k-1] + 10'(($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, room));
      room = (SPEED_MAX - s[k-1]) / (n - k);
      s[k] = s[k-1] + 14'(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, room));
    end
    flaw = FLAW_NONE;
    if ($urandom_range(0, 3) == 0) flaw = flaw_e'($urandom_range(1, 7));
    at = $urandom_range(0, n - 1);
    // Order flaws need a node before them.
    if ((flaw == FLAW_TEMP_ORDER || flaw == FLAW_SPEED_ORDER) && at == 0)
      flaw = FLAW_TEMP_RANGE;
    if (flaw == FLAW_SPEED_ORDER && s[at-1] == 0) flaw = FLAW_SPEED_RANGE;

    for (k = 0; k < n; k++) begin
      if (flaw != FLAW_NONE && k == at) begin
        case (flaw)
          FLAW_TEMP_RANGE:
            write_node(IDX_W'(k), 10'($urandom_range(TEMP_MAX + 1, 1023)), s[k], k == n - 1);
          FLAW_SPEED_RANGE:
            write_node(IDX_W'(k), t[k], 14'($urandom_range(SPEED_MAX + 1, 16383)), k == n - 1);
          FLAW_SKIP_INDEX: begin
            idx = $urandom_range(1, 15);
            if (idx == k) idx = k + 1;
            write_node(IDX_W'(idx), t[k], s[k], k == n - 1);
          end
          FLAW_INDEX_RANGE:
            write_node(IDX_W'($urandom_range(NODES, 15)), t[k], s[k], 1'($urandom));
          FLAW_TEMP_ORDER:
            write_node(IDX_W'(k), 10'($urandom_range(0, t[k-1])), s[k], k == n - 1);
          FLAW_SPEED_ORDER:
            write_node(IDX_W'(k), t[k], 14'($urandom_range(0, s[k-1] - 1)), k == n - 1);
          default: ;
        endcase
        // An abandoned load simply stops; otherwise the remaining nodes are
        // sometimes sent and must all be refused.
        if (flaw == FLAW_ABANDON || $urandom_range(0, 1) == 0) break;
      end else begin
        write_node(IDX_W'(k), t[k], s[k], k == n - 1);
      end
    end
    if (flaw == FLAW_NONE) begin
      for (k = 0; k < n; k++) known_temp[k] = t[k];
      known_size = n;
    end
  endtask

  // Queries aimed at the ends, the nodes and the segments of the known curve.
  task automatic query_burst(input int unsigned count);
    int unsigned        j, i, pick;
    logic [QUERY_W-1:0] q;
    for (j = 0; j < count; j++) begin
      pick = $urandom_range(0, 99);
      if (known_size == 0 || pick < 15) begin
        q = 16'($urandom);
      end else if (pick < 30) begin
        q = 16'($urandom_range(0, known_temp[0]));
      end else if (pick < 45) begin
        q = 16'($urandom_range(known_temp[known_size-1], known_temp[known_size-1] + 50));
      end else if (pick < 60) begin
        q = 16'(known_temp[$urandom_range(0, known_size - 1)]);
      end else begin
        i = $urandom_range(0, known_size - 1);
        if (i == known_size - 1) q = 16'(known_temp[i]);
        else q = 16'($urandom_range(known_temp[i], known_temp[i+1]));
      end
      query_speed(q);
    end
  endtask

  // Main sequence.
  initial begin : stimulus
    logic [TEMP_W-1:0]  ramp_temp [NODES];
    logic [SPEED_W-1:0] ramp_speed [NODES];
    int unsigned        k, random_start, pick, j;
    ramp_temp  = '{0, 1, 111, 222, 333, 444, 555, 777, 998, 999};
    ramp_speed = '{0, 0, 1000, 1000, 3000, 5000, 7777, 8000, 9998, 9999};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Queries before any curve exists, and nodes out of range.
    query_speed(16'hFFFF);
    write_node(0, 10'h3FF, 14'h3FFF, 1'b1);
    // A curve of one node answers every query with its speed.
    write_node(0, 10'(TEMP_MAX), 14'(SPEED_MAX), 1'b1);
    query_speed(0);
    // A full curve spanning both extremes, with a flat segment.
    for (k = 0; k < NODES; k++)
      write_node(IDX_W'(k), ramp_temp[k], ramp_speed[k], k == NODES - 1);
    query_speed(56);
    query_speed(222);
    // A load that skips an index is refused and the old curve stays.
    write_node(0, 5, 5, 1'b0);
    write_node(2, 10, 10, 1'b0);
    query_speed(999);
    // A temperature that does not rise, then a speed that falls.
    write_node(0, 5, 5, 1'b0);
    write_node(1, 5, 6, 1'b0);
    write_node(0, 5, 5, 1'b0);
    write_node(1, 6, 4, 1'b1);
    // An index past the end of the curve.
    write_node(15, 0, 0, 1'b1);
    // Index zero restarts a partial load.
    write_node(0, 5, 5, 1'b0);
    write_node(0, 100, 200, 1'b0);
    write_node(1, 200, 200, 1'b1);
    query_speed(150);
    drain_results();

    // Random part: mostly well-formed loads and aimed queries.
    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        // Noise: writes with every field at random.
        for (j = $urandom_range(1, 3); j > 0; j--)
          write_node(4'($urandom), 10'($urandom), 14'($urandom), 1'($urandom));
      end else if (pick == 1) begin
        drain_results();
      end else if (pick < 8) begin
        load_random_curve();
      end else begin
        query_burst($urandom_range(1, 8));
      end
    end

    // Let every result come back, then watch for strays.
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d requests: %0d node writes, %0d of them refused, and %0d queries.",
             items_sent, sb.n_writes, sb.n_rejected, sb.n_queries);
    $display("Queries: %0d without a curve, %0d between nodes, %0d clamped or on a node.",
             sb.n_no_curve, sb.n_interpolated, sb.n_endpoint);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
